FILE: rtl/ctr_pkg.sv
// Shared types and constants for the color temperature to RGB block.
// Depends on nothing; ctr_poly, ctr_matrix, the top level and the testbench use it by scoped names.
package ctr_pkg;

  localparam int TEMP_W = 16;
  localparam int T_W    = 14;
  localparam int CH_W   = 16;
  localparam int POLY_W = 61;
  localparam int UV_W   = 32;
  localparam int XZ_NUM_W = 35;
  localparam int XZ_DEN_W = 33;
  localparam int XZ_Q_W   = 27;
  localparam int XZ_FRAC  = 24;
  localparam int SUM_W    = 56;
  localparam int RN_NUM_W = 40;
  localparam int NUM_CH   = 3;

  localparam logic [T_W-1:0] T_MIN = 14'd1000;
  localparam logic [T_W-1:0] T_MAX = 14'd15000;

  // Locus polynomials, coefficients scaled by 10^16
  localparam logic [63:0] NU0 = 64'd8601177570000000;
  localparam logic [63:0] NU1 = 64'd1541182540000;
  localparam logic [63:0] NU2 = 64'd1286412120;
  localparam logic [63:0] DU0 = 64'd10000000000000000;
  localparam logic [63:0] DU1 = 64'd8424202350000;
  localparam logic [63:0] DU2 = 64'd7081451630;
  localparam logic [63:0] NV0 = 64'd3173987260000000;
  localparam logic [63:0] NV1 = 64'd422806245000;
  localparam logic [63:0] NV2 = 64'd420481691;
  localparam logic [63:0] DV0 = 64'd10000000000000000;
  localparam logic [63:0] DV1 = 64'd289741816000;
  localparam logic [63:0] DV2 = 64'd1614560530;

  // XYZ to linear sRGB, scaled by 10^7
  localparam logic signed [SUM_W-1:0] SRGB_M [NUM_CH][NUM_CH] = '{
    '{56'sd32404542, -56'sd15371385, -56'sd4985314},
    '{-56'sd9692660, 56'sd18760108, 56'sd415560},
    '{56'sd556434, -56'sd2040259, 56'sd10572252}
  };

  // Scale by 10^7 = 2^7 * 78125: shift, then multiply by ceil(2^50 / 78125)
  localparam int SCALE_PRE_SH = 7;
  localparam int SCALE_Y_W    = 33;
  localparam int SCALE_LO_W   = 17;
  localparam int RECIP_W      = 34;
  localparam int SCALE_SH     = 50;
  localparam logic [RECIP_W-1:0] SCALE_RECIP = 34'd14411518808;

  localparam logic [CH_W-1:0] CH_MAX = 16'hFFFF;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature_kelvin;
  } ctr_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_linear;
    logic [CH_W-1:0] green_linear;
    logic [CH_W-1:0] blue_linear;
  } ctr_out_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } ctr_chan_flag_t;

endpackage

FILE: rtl/ctr_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Payload type is set per instance; no dependencies.
interface ctr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ctr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Gives floor(num * 2^FRAC / den); needs (num * 2^FRAC) >> Q_W < den.
module ctr_div_pipe #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 61,
  parameter int Q_W   = 32,
  parameter int FRAC  = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);
  localparam int SH = Q_W - FRAC;

  logic [DEN_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [NUM_W-1:0] num_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int BIT = Q_W - 1 - k;
    logic [DEN_W-1:0] rem_in, den_in, rem_d;
    logic [Q_W-1:0]   quo_in;
    logic [NUM_W-1:0] num_in;
    logic             in_bit, ge;
    logic [DEN_W:0]   shifted;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num_i >> SH);
      assign den_in = den_i;
      assign quo_in = '0;
      assign num_in = num_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
    end

    if (BIT >= FRAC) begin : g_numbit
      assign in_bit = num_in[BIT-FRAC];
    end else begin : g_zerobit
      assign in_bit = 1'b0;
    end

    assign shifted = {rem_in, in_bit};
    assign ge      = shifted >= {1'b0, den_in};
    assign rem_d   = ge ? DEN_W'(shifted - {1'b0, den_in}) : DEN_W'(shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[Q_W-2:0], ge};
        num_q[k] <= num_in;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];
endmodule

FILE: rtl/ctr_poly.sv
// Clamp the temperature and evaluate the four locus polynomials in three stages.
// Depends on ctr_pkg for coefficients and widths.
module ctr_poly (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ctr_pkg::TEMP_W-1:0]  temp_i,
  output logic [ctr_pkg::POLY_W-1:0]  nu_o,
  output logic [ctr_pkg::POLY_W-1:0]  du_o,
  output logic [ctr_pkg::POLY_W-1:0]  nv_o,
  output logic [ctr_pkg::POLY_W-1:0]  dv_o
);
  logic [ctr_pkg::T_W-1:0]   t_d, t_q;
  logic [2*ctr_pkg::T_W-1:0] t2_q;
  logic [63:0] nu1_q, nu2_q, du1_q, du2_q, nv1_q, nv2_q, dv1_q, dv2_q;
  logic [ctr_pkg::POLY_W-1:0] nu_q, du_q, nv_q, dv_q;

  always_comb begin
    if (temp_i < 16'(ctr_pkg::T_MIN)) begin
      t_d = ctr_pkg::T_MIN;
    end else if (temp_i > 16'(ctr_pkg::T_MAX)) begin
      t_d = ctr_pkg::T_MAX;
    end else begin
      t_d = temp_i[ctr_pkg::T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= t_d;
      t2_q  <= 28'(t_d) * 28'(t_d);
      nu1_q <= ctr_pkg::NU1 * 64'(t_q);
      nu2_q <= ctr_pkg::NU2 * 64'(t2_q);
      du1_q <= ctr_pkg::DU1 * 64'(t_q);
      du2_q <= ctr_pkg::DU2 * 64'(t2_q);
      nv1_q <= ctr_pkg::NV1 * 64'(t_q);
      nv2_q <= ctr_pkg::NV2 * 64'(t2_q);
      dv1_q <= ctr_pkg::DV1 * 64'(t_q);
      dv2_q <= ctr_pkg::DV2 * 64'(t2_q);
      nu_q  <= ctr_pkg::POLY_W'(ctr_pkg::NU0 + nu1_q + nu2_q);
      du_q  <= ctr_pkg::POLY_W'(ctr_pkg::DU0 + du1_q + du2_q);
      nv_q  <= ctr_pkg::POLY_W'(ctr_pkg::NV0 + nv1_q + nv2_q);
      dv_q  <= ctr_pkg::POLY_W'(ctr_pkg::DV0 + dv2_q - dv1_q);
    end
  end

  assign nu_o = nu_q;
  assign du_o = du_q;
  assign nv_o = nv_q;
  assign dv_o = dv_q;
endmodule

FILE: rtl/ctr_matrix.sv
// XYZ to linear sRGB matrix with rounding offset, two stages, all three channels.
// Depends on ctr_pkg; feeds the per-channel scale multipliers.
module ctr_matrix #(
  parameter int OUT_FRAC_BITS = 13
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [ctr_pkg::XZ_Q_W-1:0]          x_i,
  input  logic [ctr_pkg::XZ_Q_W-1:0]          z_i,
  output logic [ctr_pkg::RN_NUM_W-1:0]        num_o  [ctr_pkg::NUM_CH],
  output ctr_pkg::ctr_chan_flag_t             flag_o [ctr_pkg::NUM_CH]
);
  localparam int SHIFT = ctr_pkg::XZ_FRAC - OUT_FRAC_BITS;
  localparam logic signed [ctr_pkg::SUM_W-1:0] HALF = 56'sd10000000 <<< (SHIFT - 1);
  localparam logic signed [ctr_pkg::SUM_W-1:0] LIMIT = 56'sd655360000000;

  logic signed [ctr_pkg::SUM_W-1:0] x_ext, z_ext;
  logic signed [ctr_pkg::SUM_W-1:0] px_q [ctr_pkg::NUM_CH];
  logic signed [ctr_pkg::SUM_W-1:0] pz_q [ctr_pkg::NUM_CH];
  logic [ctr_pkg::RN_NUM_W-1:0]     num_q  [ctr_pkg::NUM_CH];
  ctr_pkg::ctr_chan_flag_t          flag_q [ctr_pkg::NUM_CH];

  assign x_ext = ctr_pkg::SUM_W'(x_i);
  assign z_ext = ctr_pkg::SUM_W'(z_i);

  for (genvar c = 0; c < ctr_pkg::NUM_CH; c++) begin : g_ch
    logic signed [ctr_pkg::SUM_W-1:0] sum, wide;

    // Y is exactly one, so its column is a constant term
    assign sum  = px_q[c] + pz_q[c] + (ctr_pkg::SRGB_M[c][1] <<< ctr_pkg::XZ_FRAC);
    assign wide = (sum + HALF) >>> SHIFT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        px_q[c]        <= ctr_pkg::SRGB_M[c][0] * x_ext;
        pz_q[c]        <= ctr_pkg::SRGB_M[c][2] * z_ext;
        num_q[c]       <= wide[ctr_pkg::RN_NUM_W-1:0];
        flag_q[c].zero <= sum <= 0;
        flag_q[c].sat  <= wide >= LIMIT;
      end
    end

    assign num_o[c]  = num_q[c];
    assign flag_o[c] = flag_q[c];
  end
endmodule

FILE: rtl/color_temperature_to_rgb_top.sv
// Top level: color temperature in kelvin to linear sRGB, fully pipelined.
// Depends on ctr_pkg, ctr_stream_if, ctr_poly, ctr_div_pipe and ctr_matrix.
//
// One temperature enters per cycle unless the output stalls, and results leave
// in order; throughput is one item per clock. The depth is set by the bit-serial
// dividers: 32 stages for the u and v quotients and 27 for X and Z, plus
// eight arithmetic stages: three for the polynomials, one for the X and Z
// numerators, two for the matrix and two for the scale by 10^7, which is a
// reciprocal multiply. Input is clamped to 1000..15000 K, negative channels
// read as zero and large ones saturate to 0xFFFF. A stalled output freezes
// the whole pipeline; no item is lost.
module color_temperature_to_rgb_top #(
  parameter int OUT_FRAC_BITS = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ctr_stream_if.sink   in_i,
  ctr_stream_if.source out_o
);
  localparam int POLY_LAT  = 3;
  localparam int MAT_LAT   = 2;
  localparam int SCALE_LAT = 2;
  localparam int LAT = POLY_LAT + ctr_pkg::UV_W + 1 + ctr_pkg::XZ_Q_W + MAT_LAT + SCALE_LAT;
  localparam int PLO_W  = ctr_pkg::SCALE_LO_W + ctr_pkg::RECIP_W;
  localparam int PHI_W  = ctr_pkg::SCALE_Y_W - ctr_pkg::SCALE_LO_W + ctr_pkg::RECIP_W;
  localparam int PROD_W = ctr_pkg::SCALE_Y_W + ctr_pkg::RECIP_W;

  logic                              en;
  logic [LAT-1:0]                    vld_q;
  logic [ctr_pkg::POLY_W-1:0]        nu, du, nv, dv;
  logic [ctr_pkg::UV_W-1:0]          uq, vq;
  logic [ctr_pkg::XZ_NUM_W-1:0]      xn_q, zn_q;
  logic [ctr_pkg::XZ_DEN_W-1:0]      dxz_q;
  logic [ctr_pkg::XZ_Q_W-1:0]        xq, zq;
  logic [ctr_pkg::RN_NUM_W-1:0]      rn_num  [ctr_pkg::NUM_CH];
  ctr_pkg::ctr_chan_flag_t           mat_flag [ctr_pkg::NUM_CH];
  ctr_pkg::ctr_chan_flag_t           flag_q  [SCALE_LAT][ctr_pkg::NUM_CH];
  logic [ctr_pkg::CH_W-1:0]          rn_quo_q [ctr_pkg::NUM_CH];
  logic [ctr_pkg::CH_W-1:0]          chan    [ctr_pkg::NUM_CH];
  logic [36:0]                       zsub;
  logic [36:0]                       four;

  // Advance everything unless a finished item waits on the output
  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  ctr_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en),
    .temp_i (in_i.data.temperature_kelvin),
    .nu_o   (nu),
    .du_o   (du),
    .nv_o   (nv),
    .dv_o   (dv)
  );

  ctr_div_pipe #(
    .NUM_W (ctr_pkg::POLY_W), .DEN_W (ctr_pkg::POLY_W),
    .Q_W   (ctr_pkg::UV_W),   .FRAC  (ctr_pkg::UV_W)
  ) u_div_u (
    .clk_i (clk_i), .en_i (en), .num_i (nu), .den_i (du), .quo_o (uq)
  );

  ctr_div_pipe #(
    .NUM_W (ctr_pkg::POLY_W), .DEN_W (ctr_pkg::POLY_W),
    .Q_W   (ctr_pkg::UV_W),   .FRAC  (ctr_pkg::UV_W)
  ) u_div_v (
    .clk_i (clk_i), .en_i (en), .num_i (nv), .den_i (dv), .quo_o (vq)
  );

  // Numerators 3u and 4 - u - 10v (floored at zero), common divisor 2v
  assign four = 37'd4 << ctr_pkg::UV_W;
  assign zsub = 37'(uq) + 37'(vq) * 37'd10;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn_q  <= ctr_pkg::XZ_NUM_W'(uq) * 35'd3;
      zn_q  <= (zsub < four) ? ctr_pkg::XZ_NUM_W'(four - zsub) : '0;
      dxz_q <= {vq, 1'b0};
    end
  end

  ctr_div_pipe #(
    .NUM_W (ctr_pkg::XZ_NUM_W), .DEN_W (ctr_pkg::XZ_DEN_W),
    .Q_W   (ctr_pkg::XZ_Q_W),   .FRAC  (ctr_pkg::XZ_FRAC)
  ) u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (xn_q), .den_i (dxz_q), .quo_o (xq)
  );

  ctr_div_pipe #(
    .NUM_W (ctr_pkg::XZ_NUM_W), .DEN_W (ctr_pkg::XZ_DEN_W),
    .Q_W   (ctr_pkg::XZ_Q_W),   .FRAC  (ctr_pkg::XZ_FRAC)
  ) u_div_z (
    .clk_i (clk_i), .en_i (en), .num_i (zn_q), .den_i (dxz_q), .quo_o (zq)
  );

  ctr_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (xq),
    .z_i    (zq),
    .num_o  (rn_num),
    .flag_o (mat_flag)
  );

  for (genvar c = 0; c < ctr_pkg::NUM_CH; c++) begin : g_ch
    logic [ctr_pkg::SCALE_Y_W-1:0] y;
    logic [PLO_W-1:0]              plo_q;
    logic [PHI_W-1:0]              phi_q;
    logic [PROD_W-1:0]             prod;

    // Exact below full scale: drop the factor 2^7, then multiply by the reciprocal of 78125
    assign y    = rn_num[c][ctr_pkg::RN_NUM_W-1:ctr_pkg::SCALE_PRE_SH];
    assign prod = (PROD_W'(phi_q) << ctr_pkg::SCALE_LO_W) + PROD_W'(plo_q);

    always_ff @(posedge clk_i) begin
      if (en) begin
        plo_q       <= PLO_W'(y[ctr_pkg::SCALE_LO_W-1:0]) * PLO_W'(ctr_pkg::SCALE_RECIP);
        phi_q       <= PHI_W'(y[ctr_pkg::SCALE_Y_W-1:ctr_pkg::SCALE_LO_W]) *
                       PHI_W'(ctr_pkg::SCALE_RECIP);
        rn_quo_q[c] <= prod[ctr_pkg::SCALE_SH +: ctr_pkg::CH_W];
      end
    end

    // Carry the clamp flags alongside the scale multiply
    for (genvar s = 0; s < SCALE_LAT; s++) begin : g_flag
      always_ff @(posedge clk_i) begin
        if (en) begin
          flag_q[s][c] <= (s == 0) ? mat_flag[c] : flag_q[(s == 0) ? 0 : s-1][c];
        end
      end
    end

    always_comb begin
      if (flag_q[SCALE_LAT-1][c].zero) begin
        chan[c] = '0;
      end else if (flag_q[SCALE_LAT-1][c].sat) begin
        chan[c] = ctr_pkg::CH_MAX;
      end else begin
        chan[c] = rn_quo_q[c];
      end
    end
  end

  assign out_o.data.red_linear   = chan[0];
  assign out_o.data.green_linear = chan[1];
  assign out_o.data.blue_linear  = chan[2];

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted item missing from pipeline");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !((flag_q[SCALE_LAT-1][0].zero && flag_q[SCALE_LAT-1][0].sat) ||
                      (flag_q[SCALE_LAT-1][1].zero && flag_q[SCALE_LAT-1][1].sat) ||
                      (flag_q[SCALE_LAT-1][2].zero && flag_q[SCALE_LAT-1][2].sat)))
    else $error("channel both negative and saturated");
`endif
endmodule

FILE: tb/sv/tb.sv
// Testbench for color_temperature_to_rgb_top: kelvin in, linear sRGB triple out.
// Depends on ctr_pkg and ctr_stream_if; predicts each triple in fixed point
// and compares it with the block's output in arrival order.
`timescale 1ns / 1ps

module tb;

  localparam int FRAC_BITS = 13;
  localparam int HOLD_CYCLES = 300;
  localparam int PIPE_DEPTH = 67;

  logic clk_i;
  logic rst_ni;

  ctr_stream_if #(.payload_t(ctr_pkg::ctr_in_t))  in_if ();
  ctr_stream_if #(.payload_t(ctr_pkg::ctr_out_t)) out_if ();

  color_temperature_to_rgb_top #(.OUT_FRAC_BITS(FRAC_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  ctr_pkg::ctr_out_t rgb_expected [$];
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned hold_left;
  logic hold_start;
  int unsigned ready_phase;

  // floor(n * 2^f / d), all ones on a zero divisor
  function automatic longint unsigned scaled_quotient(longint unsigned n,
                                                      longint unsigned d, int f);
    longint unsigned q;
    longint unsigned r;
    if (d == 0) return '1;
    q = n / d;
    r = n % d;
    for (int i = 0; i < f; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic ctr_pkg::ctr_out_t kelvin_to_rgb(logic [ctr_pkg::TEMP_W-1:0] kelvin);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned nu, du, nv, dv, uq, vq, xq, zq, zn, sub;
    longint signed xyz [3];
    longint signed mtx [3][3];
    longint signed s, div, half;
    logic [ctr_pkg::CH_W-1:0] ch_val [3];
    ctr_pkg::ctr_out_t res;
    mtx = '{'{32404542, -15371385, -4985314},
            '{-9692660, 18760108, 415560},
            '{556434, -2040259, 10572252}};
    t = kelvin;
    if (t < 1000) t = 1000;
    if (t > 15000) t = 15000;
    t2 = t * t;
    nu = 64'd8601177570000000 + 64'd1541182540000 * t + 64'd1286412120 * t2;
    du = 64'd10000000000000000 + 64'd8424202350000 * t + 64'd7081451630 * t2;
    nv = 64'd3173987260000000 + 64'd422806245000 * t + 64'd420481691 * t2;
    dv = 64'd10000000000000000 + 64'd1614560530 * t2 - 64'd289741816000 * t;
    uq = scaled_quotient(nu, du, 32);
    vq = scaled_quotient(nv, dv, 32);
    xq = scaled_quotient(3 * uq, 2 * vq, 24);
    sub = uq + 10 * vq;
    zn = (sub < (64'd4 << 32)) ? (64'd4 << 32) - sub : 64'd0;
    zq = scaled_quotient(zn, 2 * vq, 24);
    if (xq > 64'hFF_FFFF_FFFF) xq = 64'hFF_FFFF_FFFF;
    if (zq > 64'hFF_FFFF_FFFF) zq = 64'hFF_FFFF_FFFF;
    xyz[0] = xq;
    xyz[1] = 64'sd1 << 24;
    xyz[2] = zq;
    div = 64'sd10000000 << (24 - FRAC_BITS);
    half = div / 2;
    for (int c = 0; c < 3; c++) begin
      s = mtx[c][0] * xyz[0] + mtx[c][1] * xyz[1] + mtx[c][2] * xyz[2];
      if (s <= 0) ch_val[c] = '0;
      else if ((s + half) / div > 65535) ch_val[c] = 16'hFFFF;
      else ch_val[c] = 16'((s + half) / div);
    end
    res.red_linear = ch_val[0];
    res.green_linear = ch_val[1];
    res.blue_linear = ch_val[2];
    return res;
  endfunction

  // Record accepted temperatures and check every delivered triple
  always @(posedge clk_i) begin
    ctr_pkg::ctr_out_t want;
    if (rst_ni && in_if.valid && in_if.ready)
      rgb_expected.push_back(kelvin_to_rgb(in_if.data.temperature_kelvin));
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rgb_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected triple %h/%h/%h", out_if.data.red_linear,
                   out_if.data.green_linear, out_if.data.blue_linear);
      end else begin
        want = rgb_expected.pop_front();
        if (want !== out_if.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgb mismatch: expected %h/%h/%h got %h/%h/%h",
                     want.red_linear, want.green_linear, want.blue_linear,
                     out_if.data.red_linear, out_if.data.green_linear,
                     out_if.data.blue_linear);
        end
      end
    end
  end

  // Long output hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver: alternate always-ready stretches with random stalls
  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 1;
    if (hold_left != 0 || hold_start) out_if.ready <= 1'b0;
    else if (ready_phase[6]) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_temp(logic [ctr_pkg::TEMP_W-1:0] kelvin);
    in_if.valid <= 1'b1;
    in_if.data.temperature_kelvin <= kelvin;
    do @(posedge clk_i); while (!in_if.ready);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (rgb_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [ctr_pkg::TEMP_W-1:0] corners [$];
    corners = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1500, 16'd2700,
                16'd4000, 16'd5000, 16'd6500, 16'd10000, 16'd14999, 16'd15000,
                16'd15001, 16'd16383, 16'd16384, 16'h5555, 16'hAAAA,
                16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
    foreach (corners[i]) send_temp(corners[i]);
    drain_results();
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) send_temp(16'($urandom_range(0, 65535)));
      else send_temp(16'($urandom_range(1000, 15000)));
    end
  endtask

  // Keep offering items while the output is held off so the input stalls
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    burst_left = 200;
    for (int i = 0; i < 150; i++) send_temp(16'($urandom_range(1000, 15000)));
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    ready_phase = 0;
    burst_left = 0;
    mismatches = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    drain_results();
    test_backpressure();
    test_random(300);
    drain_results();
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
